// ===== sv/text_console_char_handler_defines.svh =====
// assertion macros of the checker file of the text console block
`ifndef TEXT_CONSOLE_CHAR_HANDLER_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_HANDLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TCCH_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcch assertion failed");

// next-cycle implication, disabled during reset
`define TCCH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcch assertion failed");

`endif

// ===== sv/tcch_pkg.sv =====
// shared types and constants of the text console character handler
package tcch_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned ROW_W   = 5;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CELL_W  = 16;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic REG_ATTR_IDX = 1'b0;

  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  localparam logic [CHAR_W-1:0] CHAR_BS  = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF  = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_FF  = 8'h0C;
  localparam logic [CHAR_W-1:0] CHAR_CR  = 8'h0D;

  localparam int unsigned TAB_STEP = 8;

  typedef enum logic {
    CMD_PUT  = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } result_t;

endpackage

// ===== sv/tcch_screen_mem.sv =====
// screen cell store, one write port and one registered read port
module tcch_screen_mem import tcch_pkg::*; #(
  parameter int unsigned DEPTH  = COLUMNS_DEF * ROWS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  mem_ctl_t          ctl_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [CELL_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tcch_ctrl.sv =====
// command sequencer: cursor, scroll base, blanking sweeps and cell accesses
module tcch_ctrl import tcch_pkg::*; #(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF,
  parameter int unsigned ADDR_W  = $clog2(COLUMNS * ROWS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [ROW_W-1:0]  read_row_i,
  input  logic [COL_W-1:0]  read_col_i,
  input  logic [CHAR_W-1:0] attr_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output result_t           res_o,
  output mem_ctl_t          mem_ctl_o,
  output logic [ADDR_W-1:0] waddr_o,
  output logic [CELL_W-1:0] wdata_o,
  output logic [ADDR_W-1:0] raddr_o,
  input  logic [CELL_W-1:0] rdata_i
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned PW    = RW + 1;
  localparam int unsigned CX    = CW + 1;

  typedef enum logic [2:0] {
    S_SWEEP = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                             input logic [RW-1:0] top);
    logic [PW-1:0] sum;
    sum = PW'(lrow) + PW'(top);
    if (sum >= PW'(ROWS)) begin
      sum = sum - PW'(ROWS);
    end
    return RW'(sum);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [RW-1:0] prow,
                                                  input logic [CW-1:0] col);
    return ADDR_W'(prow * COLUMNS) + ADDR_W'(col);
  endfunction

  state_e              state_q, state_d;
  cmd_e                cmd_q;
  logic [CHAR_W-1:0]   char_q;
  logic                rd_ok_q;
  logic [RW-1:0]       row_q, row_d;
  logic [CW-1:0]       col_q, col_d;
  logic [RW-1:0]       top_q, top_d;
  logic [ADDR_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]   last_q, last_d;
  logic [ADDR_W-1:0]   base_q, base_d;
  logic [CELL_W-1:0]   blank_q, blank_d;

  logic                accept;
  logic                commit;
  logic                rd_in_range;
  logic [CW-1:0]       ncol;
  logic [PW-1:0]       nrow_x;
  logic [RW-1:0]       nrow;
  logic [CX-1:0]       col_x;
  logic [CX-1:0]       step_x;
  logic                put_wr;
  logic [CW-1:0]       put_col;
  logic [CHAR_W-1:0]   put_char;
  logic                clear;
  logic                scroll;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign commit      = (state_q == S_EXEC) && out_free_i;
  assign rd_in_range = (32'(read_row_i) < ROWS) && (32'(read_col_i) < COLUMNS);
  assign raddr_o     = cell_addr(phys_row(RW'(read_row_i), top_q), CW'(read_col_i));

  // cursor update of a put
  always_comb begin
    ncol     = col_q;
    nrow_x   = PW'(row_q);
    put_wr   = 1'b0;
    put_col  = col_q;
    put_char = char_q;
    clear    = 1'b0;
    col_x    = CX'(col_q);
    step_x   = '0;
    case (char_q)
      CHAR_LF: begin
        ncol   = '0;
        nrow_x = nrow_x + 1'b1;
      end
      CHAR_BS: begin
        if (col_q != '0) begin
          ncol     = col_q - 1'b1;
          put_wr   = 1'b1;
          put_col  = col_q - 1'b1;
          put_char = BLANK_CHAR;
        end
      end
      CHAR_FF: begin
        clear = 1'b1;
      end
      CHAR_CR: begin
        ncol = '0;
      end
      CHAR_TAB: begin
        step_x = (col_x + CX'(TAB_STEP)) & ~CX'(TAB_STEP - 1);
        if (step_x >= CX'(COLUMNS)) begin
          ncol   = '0;
          nrow_x = nrow_x + 1'b1;
        end else begin
          ncol = CW'(step_x);
        end
      end
      default: begin
        put_wr = 1'b1;
        step_x = col_x + 1'b1;
        if (step_x >= CX'(COLUMNS)) begin
          ncol   = '0;
          nrow_x = nrow_x + 1'b1;
        end else begin
          ncol = CW'(step_x);
        end
      end
    endcase
    scroll = (nrow_x >= PW'(ROWS));
    nrow   = scroll ? RW'(ROWS - 1) : RW'(nrow_x);
  end

  // result of the item in flight
  always_comb begin
    res_valid_o = commit;
    if (cmd_q == CMD_READ) begin
      res_o.cell_val = rd_ok_q ? rdata_i : '0;
      res_o.row      = ROW_W'(row_q);
      res_o.col      = COL_W'(col_q);
    end else begin
      res_o.cell_val = '0;
      res_o.row      = clear ? '0 : ROW_W'(nrow);
      res_o.col      = clear ? '0 : COL_W'(ncol);
    end
  end

  // memory requests
  always_comb begin
    mem_ctl_o.rd_en = accept && (command_i == CMD_READ) && rd_in_range;
    if (state_q == S_SWEEP) begin
      mem_ctl_o.wr_en = 1'b1;
      waddr_o         = base_q + cnt_q;
      wdata_o         = blank_q;
    end else begin
      mem_ctl_o.wr_en = commit && (cmd_q == CMD_PUT) && put_wr;
      waddr_o         = cell_addr(phys_row(row_q, top_q), put_col);
      wdata_o         = {attr_i, put_char};
    end
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    top_d   = top_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    base_d  = base_q;
    blank_d = blank_q;
    case (state_q)
      S_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == last_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d = S_IDLE;
          if (cmd_q == CMD_PUT) begin
            if (clear) begin
              state_d = S_SWEEP;
              row_d   = '0;
              col_d   = '0;
              cnt_d   = '0;
              base_d  = '0;
              last_d  = ADDR_W'(CELLS - 1);
              blank_d = {attr_i, BLANK_CHAR};
            end else begin
              row_d = nrow;
              col_d = ncol;
              if (scroll) begin
                state_d = S_SWEEP;
                cnt_d   = '0;
                base_d  = cell_addr(top_q, '0);
                last_d  = ADDR_W'(COLUMNS - 1);
                blank_d = {attr_i, BLANK_CHAR};
                top_d   = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
              end
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      cnt_q   <= '0;
      last_q  <= ADDR_W'(CELLS - 1);
      base_q  <= '0;
      blank_q <= {RESET_ATTR, BLANK_CHAR};
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      base_q  <= base_d;
      blank_q <= blank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(command_i);
      char_q  <= char_code_i;
      rd_ok_q <= rd_in_range;
    end
  end

endmodule

// ===== sv/text_console_char_handler.sv =====
// top level of the text console character handler
// A read or an ordinary put waits in the execute state until the output
// register is free, then its result is registered there; the next request
// is taken in the cycle after the result is produced, also while that
// result still waits in the output register. Puts and blanking share the
// single write port of the screen store: a put that scrolls blanks the new
// bottom row, a form feed blanks the whole store, and after reset a clearing
// pass over every cell runs before the first request is taken. Scrolling
// moves a row base pointer instead of copying cells. The attribute register
// can be written over the APB port at any time the block is idle.
module text_console_char_handler import tcch_pkg::*; #(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               command_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [ROW_W-1:0]   read_row_i,
  input  logic [COL_W-1:0]   read_col_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CELL_W-1:0]  cell_value_o,
  output logic [ROW_W-1:0]   cursor_row_o,
  output logic [COL_W-1:0]   cursor_col_o
);

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);

  logic [CHAR_W-1:0] attr_q;
  logic              out_valid_q;
  result_t           out_q;
  logic              out_free;
  logic              res_valid;
  result_t           res;
  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] rdata;
  logic              attr_sel;

  assign attr_sel = (paddr[PADDR_W-1:2] == REG_ATTR_IDX);
  assign pready   = 1'b1;
  assign prdata   = attr_sel ? PDATA_W'(attr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (psel && penable && pwrite && pready && attr_sel) begin
      attr_q <= pwdata[CHAR_W-1:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = out_q.cell_val;
  assign cursor_row_o = out_q.row;
  assign cursor_col_o = out_q.col;

  tcch_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .ADDR_W  (ADDR_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .char_code_i (char_code_i),
    .read_row_i  (read_row_i),
    .read_col_i  (read_col_i),
    .attr_i      (attr_q),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_ctl_o   (mem_ctl),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  tcch_screen_mem #(
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule

// ===== sv/tcch_checker.sv =====
// port-level checker of the text console block and its bind
`include "text_console_char_handler_defines.svh"

module tcch_checker import tcch_pkg::*; #(
  parameter int unsigned COLUMNS = COLUMNS_DEF,
  parameter int unsigned ROWS    = ROWS_DEF
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [CELL_W-1:0] cell_value_o,
  input logic [ROW_W-1:0]  cursor_row_o,
  input logic [COL_W-1:0]  cursor_col_o
);

  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  `TCCH_ASSERT(a_cursor_bounds, out_valid_o, (32'(cursor_row_o) < ROWS) && (32'(cursor_col_o) < COLUMNS))
  `TCCH_ASSERT(a_no_spurious_result, out_valid_o, pend_q != 2'd0)
  `TCCH_ASSERT(a_pending_limit, in_acc, pend_q < 2'd2)
  `TCCH_ASSERT_NEXT(a_result_held, out_valid_o && out_stall_i, out_valid_o && $stable(cell_value_o) && $stable(cursor_row_o) && $stable(cursor_col_o))

endmodule

bind text_console_char_handler tcch_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcch_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .cell_value_o (cell_value_o),
  .cursor_row_o (cursor_row_o),
  .cursor_col_o (cursor_col_o)
);

// ===== test/text_console_char_handler_tb.sv =====
// testbench of the text console character handler: predicted screen and cursor, checked per request
module text_console_char_handler_tb import tcch_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = ROWS_DEF * COLUMNS_DEF + 100;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [PADDR_W-1:0] ATTR_ADDR = PADDR_W'(REG_ATTR_IDX) << 2;

  typedef struct packed {
    cmd_e              cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } request_t;

  class console_scoreboard;
    typedef struct packed {
      logic [CELL_W-1:0] cell_val;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
    } screen_result_t;

    logic [CELL_W-1:0] screen [COLUMNS_DEF*ROWS_DEF];
    int unsigned       cur_row;
    int unsigned       cur_col;
    logic [CHAR_W-1:0] attr;
    screen_result_t    result_q[$];
    int unsigned       errors;

    function new();
      attr    = RESET_ATTR;
      cur_row = 0;
      cur_col = 0;
      errors  = 0;
      foreach (screen[i]) screen[i] = {RESET_ATTR, BLANK_CHAR};
    endfunction

    function void set_attribute(logic [CHAR_W-1:0] value);
      attr = value;
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction

    function void next_line();
      cur_col = 0;
      cur_row++;
    endfunction

    function void put_char(logic [CHAR_W-1:0] ch);
      case (ch)
        CHAR_LF: next_line();
        CHAR_BS: begin
          if (cur_col > 0) begin
            cur_col--;
            screen[cur_row*COLUMNS_DEF + cur_col] = {attr, BLANK_CHAR};
          end
        end
        CHAR_FF: begin
          foreach (screen[i]) screen[i] = {attr, BLANK_CHAR};
          cur_row = 0;
          cur_col = 0;
        end
        CHAR_CR: cur_col = 0;
        CHAR_TAB: begin
          cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
          if (cur_col >= COLUMNS_DEF) next_line();
        end
        default: begin
          screen[cur_row*COLUMNS_DEF + cur_col] = {attr, ch};
          cur_col++;
          if (cur_col >= COLUMNS_DEF) next_line();
        end
      endcase
      if (cur_row >= ROWS_DEF) begin
        for (int unsigned i = 0; i < (ROWS_DEF - 1) * COLUMNS_DEF; i++)
          screen[i] = screen[i + COLUMNS_DEF];
        for (int unsigned i = (ROWS_DEF - 1) * COLUMNS_DEF; i < ROWS_DEF * COLUMNS_DEF; i++)
          screen[i] = {attr, BLANK_CHAR};
        cur_row = ROWS_DEF - 1;
      end
    endfunction

    function void note_request(request_t req);
      screen_result_t res;
      res.cell_val = '0;
      if (req.cmd == CMD_PUT)
        put_char(req.ch);
      else if (req.row < ROWS_DEF && req.col < COLUMNS_DEF)
        res.cell_val = screen[int'(req.row)*COLUMNS_DEF + int'(req.col)];
      res.row = ROW_W'(cur_row);
      res.col = COL_W'(cur_col);
      result_q.push_back(res);
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [CELL_W-1:0] cell_val, logic [ROW_W-1:0] row,
                      logic [COL_W-1:0] col);
      screen_result_t exp;
      if (result_q.size() == 0) begin
        report("result with no request waiting");
      end else begin
        exp = result_q.pop_front();
        if (cell_val !== exp.cell_val)
          report($sformatf("cell_value got %h expected %h", cell_val, exp.cell_val));
        if (row !== exp.row)
          report($sformatf("cursor_row got %0d expected %0d", row, exp.row));
        if (col !== exp.col)
          report($sformatf("cursor_col got %0d expected %0d", col, exp.col));
      end
    endtask

    task flag_leftovers();
      if (result_q.size() != 0)
        report($sformatf("%0d results never arrived", result_q.size()));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               command_i = 1'b0;
  logic [CHAR_W-1:0]  char_code_i = '0;
  logic [ROW_W-1:0]   read_row_i = '0;
  logic [COL_W-1:0]   read_col_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [CELL_W-1:0]  cell_value_o;
  logic [ROW_W-1:0]   cursor_row_o;
  logic [COL_W-1:0]   cursor_col_o;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  console_scoreboard sb = new();

  text_console_char_handler dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_value_o (cell_value_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_request('{cmd_e'(command_i), char_code_i, read_row_i, read_col_i});
      if (out_valid_o && !out_stall_i)
        sb.check_result(cell_value_o, cursor_row_o, cursor_col_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("** text_console_char_handler: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic request_t make_request(cmd_e cmd, logic [CHAR_W-1:0] ch,
                                            logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    request_t req;
    req.cmd = cmd;
    req.ch  = ch;
    req.row = row;
    req.col = col;
    return req;
  endfunction

  task automatic send_request(request_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    command_i   = req.cmd;
    char_code_i = req.ch;
    read_row_i  = req.row;
    read_col_i  = req.col;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // the block may still be blanking rows after its last result
  task automatic write_attribute(logic [CHAR_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ATTR_ADDR;
    pwdata  = PDATA_W'(value);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_attribute(value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic run_phase(int unsigned count, int unsigned idle_p, int unsigned stall_p,
                           bit with_hold, bit with_pause);
    request_t    req;
    int unsigned line_left;
    int unsigned pick;
    send_idle_pct = idle_p;
    stall_pct     = stall_p;
    line_left     = 0;
    for (int unsigned k = 0; k < count; k++) begin
      if (with_hold && k == 20) hold_left = HOLD_CYCLES;
      if (with_pause && k == count / 2) wait_drained();
      req = make_request(CMD_PUT, CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
      if ($urandom_range(99) < 15) begin
        req.cmd = CMD_READ;
        pick = $urandom_range(9);
        if (pick == 0) begin
          req.row = ROW_W'($urandom_range(31));
          req.col = COL_W'($urandom_range(127));
        end else begin
          req.row = (pick < 5) ? ROW_W'(sb.cur_row) : ROW_W'($urandom_range(ROWS_DEF - 1));
          req.col = COL_W'($urandom_range(COLUMNS_DEF - 1));
        end
      end else if (line_left == 0) begin
        req.ch = ($urandom_range(99) < 80) ? CHAR_LF : CHAR_CR;
        pick = $urandom_range(9);
        line_left = (pick < 4) ? $urandom_range(2) :
                    (pick < 8) ? $urandom_range(30, 3) : $urandom_range(100, 60);
      end else begin
        line_left--;
        pick = $urandom_range(999);
        if (pick < 80) req.ch = CHAR_TAB;
        else if (pick < 130) req.ch = CHAR_BS;
        else if (pick < 133) req.ch = CHAR_FF;
      end
      send_request(req);
    end
    in_valid_i = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset contents, out of screen reads, edge bytes and every control
    send_request(make_request(CMD_READ, 8'h00, 5'd0, 7'd0));
    send_request(make_request(CMD_READ, 8'hFF, 5'd24, 7'd79));
    send_request(make_request(CMD_READ, 8'h55, 5'd25, 7'd0));
    send_request(make_request(CMD_READ, 8'hAA, 5'd0, 7'd80));
    send_request(make_request(CMD_READ, 8'hFF, 5'd31, 7'd127));
    send_request(make_request(CMD_PUT, 8'h41, 5'd31, 7'd127));
    send_request(make_request(CMD_PUT, 8'h00, 5'd0, 7'd0));
    send_request(make_request(CMD_PUT, 8'hFF, 5'd10, 7'd42));
    send_request(make_request(CMD_PUT, CHAR_BS, 5'd0, 7'd0));
    send_request(make_request(CMD_READ, 8'h00, 5'd0, 7'd2));
    send_request(make_request(CMD_PUT, CHAR_CR, 5'd0, 7'd0));
    send_request(make_request(CMD_PUT, CHAR_BS, 5'd0, 7'd0));
    send_request(make_request(CMD_PUT, CHAR_TAB, 5'd0, 7'd0));
    send_request(make_request(CMD_PUT, 8'h7E, 5'd0, 7'd0));
    send_request(make_request(CMD_PUT, CHAR_TAB, 5'd0, 7'd0));
    send_request(make_request(CMD_PUT, CHAR_LF, 5'd0, 7'd0));
    send_request(make_request(CMD_READ, 8'h00, 5'd0, 7'd0));
    send_request(make_request(CMD_READ, 8'h00, 5'd0, 7'd8));
    send_request(make_request(CMD_PUT, CHAR_FF, 5'd0, 7'd0));
    send_request(make_request(CMD_READ, 8'h00, 5'd0, 7'd0));
    send_request(make_request(CMD_READ, 8'h00, 5'd24, 7'd79));
    in_valid_i = 1'b0;

    write_attribute(8'hFF);
    run_phase(210, 0, 0, 1'b1, 1'b0);
    write_attribute(8'h00);
    run_phase(210, 63, 0, 1'b0, 1'b1);
    write_attribute(CHAR_W'($urandom));
    run_phase(210, 0, 63, 1'b0, 1'b0);
    write_attribute(8'h80);
    run_phase(210, 14, 14, 1'b0, 1'b0);

    stall_pct = 0;
    wait_drained();
    repeat (100) @(negedge clk_i);
    sb.flag_leftovers();
    if (sb.errors == 0) begin
      $display("** text_console_char_handler: PASSED **");
    end else begin
      $display("** text_console_char_handler: FAILED **");
    end
    $finish;
  end

endmodule
